// ----- rtl/boae_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded ordered array engine package
// Field widths, operation and status codes, and the control structs shared
// by the top level and the walk sequencer.
// ----------------------------------------------------------------------------
package boae_pkg;

   localparam int OPC_W   = 3;
   localparam int IDX_W   = 8;
   localparam int ITEM_W  = 32;
   localparam int VAL_W   = 32;
   localparam int POS_W   = 9;
   localparam int CNT_O_W = 9;
   localparam int ST_W    = 2;

   localparam int DEPTH_DEF     = 256;
   localparam int WORD_BITS_DEF = 32;

   localparam logic [OPC_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OPC_W-1:0] OP_POP    = 3'd1;
   localparam logic [OPC_W-1:0] OP_INSERT = 3'd2;
   localparam logic [OPC_W-1:0] OP_DELETE = 3'd3;
   localparam logic [OPC_W-1:0] OP_READ   = 3'd4;
   localparam logic [OPC_W-1:0] OP_FIND   = 3'd5;
   localparam logic [OPC_W-1:0] OP_REMOVE = 3'd6;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic             start;
      logic [OPC_W-1:0] op;
   } walk_cmd_type;

   typedef struct packed {
      logic done;
      logic found;
   } walk_sts_type;

endpackage
`default_nettype wire

// ----- rtl/boae_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one array operation per transaction.
// ----------------------------------------------------------------------------
interface boae_req_if;
   logic                                     valid;
   logic                                     ready;
   logic        [boae_pkg::OPC_W-1:0]        opcode;
   logic        [boae_pkg::IDX_W-1:0]        index;
   logic signed [boae_pkg::ITEM_W-1:0]       item;

   modport source (output valid, output opcode, output index, output item, input ready);
   modport sink   (input valid, input opcode, input index, input item, output ready);
endinterface
`default_nettype wire

// ----- rtl/boae_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result per transaction.
// ----------------------------------------------------------------------------
interface boae_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [boae_pkg::VAL_W-1:0]    value;
   logic signed [boae_pkg::POS_W-1:0]    position;
   logic        [boae_pkg::CNT_O_W-1:0]  removed_count;
   logic        [boae_pkg::CNT_O_W-1:0]  fill;
   logic                                 empty_res;
   logic        [boae_pkg::ST_W-1:0]     status;

   modport source (output valid, output value, output position, output removed_count,
                   output fill, output empty_res, output status, input ready);
   modport sink   (input valid, input value, input position, input removed_count,
                   input fill, input empty_res, input status, output ready);
endinterface
`default_nettype wire

// ----- rtl/boae_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module boae_ram #(
   parameter int WIDTH = boae_pkg::WORD_BITS_DEF,
   parameter int DEPTH = boae_pkg::DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/boae_walker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Array walk sequencer
// Steps an address counter over the stored entries, one memory read per
// cycle, and applies the shared compare and shift unit to each word read.
// ----------------------------------------------------------------------------
module boae_walker #(
   parameter int DEPTH     = boae_pkg::DEPTH_DEF,
   parameter int WORD_BITS = boae_pkg::WORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire boae_pkg::walk_cmd_type       cmd,
   input  wire logic [$clog2(DEPTH+1)-1:0]   cmd_idx,
   input  wire logic [$clog2(DEPTH+1)-1:0]   cmd_cnt,
   input  wire logic [WORD_BITS-1:0]         cmd_item,
   output boae_pkg::walk_sts_type            sts,
   output logic      [WORD_BITS-1:0]         res_value,
   output logic      [$clog2(DEPTH)-1:0]     res_pos,
   output logic      [$clog2(DEPTH+1)-1:0]   res_removed
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [1:0] W_IDLE = 2'd0;
   localparam logic [1:0] W_WALK = 2'd1;
   localparam logic [1:0] W_FIN  = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [boae_pkg::OPC_W-1:0]  op_ff, op_in;
   logic [WORD_BITS-1:0]        item_ff, item_in;
   logic [AW-1:0]               rd_addr_ff, rd_addr_in;
   logic [CW-1:0]               rd_left_ff, rd_left_in;
   logic                        dv_ff, dv_in;
   logic [AW-1:0]               da_ff, da_in;
   logic                        first_ff, first_in;
   logic [CW-1:0]               wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]               removed_ff, removed_in;
   logic                        found_ff, found_in;
   logic [AW-1:0]               pos_ff, pos_in;
   logic [WORD_BITS-1:0]        value_ff, value_in;
   logic [AW-1:0]               fin_addr_ff, fin_addr_in;

   logic [AW-1:0]        st_addr;
   logic [CW-1:0]        st_left;
   logic [AW-1:0]        st_fin;
   logic [CW-1:0]        cnt_m1;
   logic                 rd_en;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] rd_data;
   logic                 hit;

   boae_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   // Starting address, number of reads and final write address per operation.
   always_comb begin
      cnt_m1  = cmd_cnt - CW'(1);
      st_addr = '0;
      st_left = '0;
      st_fin  = '0;
      case (cmd.op)
         boae_pkg::OP_PUSH: begin
            st_fin = AW'(cmd_cnt);
         end
         boae_pkg::OP_POP: begin
            st_addr = AW'(cnt_m1);
            st_left = CW'(1);
         end
         boae_pkg::OP_READ: begin
            st_addr = AW'(cmd_idx);
            st_left = CW'(1);
         end
         boae_pkg::OP_DELETE: begin
            st_addr = AW'(cmd_idx);
            st_left = cmd_cnt - cmd_idx;
         end
         boae_pkg::OP_INSERT: begin
            // Walk downward so each word moves up before it is overwritten.
            st_addr = AW'(cnt_m1);
            st_left = cmd_cnt - cmd_idx;
            st_fin  = AW'(cmd_idx);
         end
         boae_pkg::OP_FIND, boae_pkg::OP_REMOVE: begin
            st_left = cmd_cnt;
         end
         default: begin
            st_left = '0;
         end
      endcase
   end

   assign hit   = dv_ff && (rd_data == item_ff);
   assign rd_en = (state_ff == W_WALK) && (rd_left_ff != '0);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      item_in     = item_ff;
      rd_addr_in  = rd_addr_ff;
      rd_left_in  = rd_left_ff;
      dv_in       = 1'b0;
      da_in       = da_ff;
      first_in    = first_ff;
      wr_ptr_in   = wr_ptr_ff;
      removed_in  = removed_ff;
      found_in    = found_ff;
      pos_in      = pos_ff;
      value_in    = value_ff;
      fin_addr_in = fin_addr_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = rd_data;

      case (state_ff)
         W_IDLE: begin
            if (cmd.start) begin
               state_in    = W_WALK;
               op_in       = cmd.op;
               item_in     = cmd_item;
               rd_addr_in  = st_addr;
               rd_left_in  = st_left;
               fin_addr_in = st_fin;
               first_in    = 1'b1;
               wr_ptr_in   = '0;
               removed_in  = '0;
               found_in    = 1'b0;
               pos_in      = '0;
               value_in    = '0;
            end
         end
         W_WALK: begin
            if (rd_en) begin
               dv_in      = 1'b1;
               da_in      = rd_addr_ff;
               rd_left_in = rd_left_ff - CW'(1);
               if (op_ff == boae_pkg::OP_INSERT) begin
                  rd_addr_in = rd_addr_ff - AW'(1);
               end else begin
                  rd_addr_in = rd_addr_ff + AW'(1);
               end
            end
            if (dv_ff) begin
               first_in = 1'b0;
               case (op_ff)
                  boae_pkg::OP_POP, boae_pkg::OP_READ: begin
                     value_in = rd_data;
                  end
                  boae_pkg::OP_DELETE: begin
                     if (first_ff) begin
                        value_in = rd_data;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = da_ff - AW'(1);
                     end
                  end
                  boae_pkg::OP_INSERT: begin
                     wr_en   = 1'b1;
                     wr_addr = da_ff + AW'(1);
                  end
                  boae_pkg::OP_REMOVE: begin
                     if (hit) begin
                        removed_in = removed_ff + CW'(1);
                     end else begin
                        wr_en     = 1'b1;
                        wr_addr   = wr_ptr_ff[AW-1:0];
                        wr_ptr_in = wr_ptr_ff + CW'(1);
                     end
                  end
                  default: begin
                     first_in = 1'b0;
                  end
               endcase
            end
            if ((op_ff == boae_pkg::OP_FIND) && hit) begin
               // The first match ends the walk; reads still in flight are dropped.
               found_in   = 1'b1;
               pos_in     = da_ff;
               rd_left_in = '0;
               dv_in      = 1'b0;
               state_in   = W_FIN;
            end else if ((rd_left_ff == '0) && !dv_ff) begin
               state_in = W_FIN;
            end
         end
         W_FIN: begin
            if ((op_ff == boae_pkg::OP_PUSH) || (op_ff == boae_pkg::OP_INSERT)) begin
               wr_en   = 1'b1;
               wr_addr = fin_addr_ff;
               wr_data = item_ff;
            end
            state_in = W_IDLE;
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= W_IDLE;
         dv_ff      <= 1'b0;
         rd_left_ff <= '0;
      end else begin
         state_ff   <= state_in;
         dv_ff      <= dv_in;
         rd_left_ff <= rd_left_in;
      end
      op_ff       <= op_in;
      item_ff     <= item_in;
      rd_addr_ff  <= rd_addr_in;
      da_ff       <= da_in;
      first_ff    <= first_in;
      wr_ptr_ff   <= wr_ptr_in;
      removed_ff  <= removed_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      value_ff    <= value_in;
      fin_addr_ff <= fin_addr_in;
   end

   assign sts.done    = (state_ff == W_FIN);
   assign sts.found   = found_ff;
   assign res_value   = value_ff;
   assign res_pos     = pos_ff;
   assign res_removed = removed_ff;

   // A shifted word is never written where the same cycle reads.
   a_no_rw_collision : assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr_ff))
      else $error("memory write and read hit the same address");

   a_idle_no_write : assert property (@(posedge clock) disable iff (reset)
      (state_ff == W_IDLE) |-> !wr_en)
      else $error("memory written while sequencer idle");

   a_fin_after_walk : assert property (@(posedge clock) disable iff (reset)
      (state_ff == W_FIN) |=> (state_ff == W_IDLE))
      else $error("sequencer did not return to idle after finishing");

endmodule
`default_nettype wire

// ----- rtl/bounded_ordered_array_engine_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Each request walks N stored entries: 1 for pop and read, fill - index for insert and
// delete, fill for find and remove all; find stops at its first match. Push and an insert
// at the fill walk none; rejected requests and opcode seven skip the walk, and a response
// is held in its register until ready. One transaction at a time; ready rises with the
// response valid. Reset: fill count clears at once; memory not swept.
// ----------------------------------------------------------------------------
// Bounded ordered array engine
// Ordered array of words with a fill count: push, pop, insert, delete, read,
// find and remove all, one result per request.
// ----------------------------------------------------------------------------
module bounded_ordered_array_engine_core #(
   parameter int DEPTH     = boae_pkg::DEPTH_DEF,
   parameter int WORD_BITS = boae_pkg::WORD_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   boae_req_if.sink         req_chan,
   boae_rsp_if.source       rsp_chan
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int CMP_W = (CW > boae_pkg::IDX_W) ? CW : boae_pkg::IDX_W;

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_BUSY = 2'd1;
   localparam logic [1:0] T_HOLD = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [boae_pkg::OPC_W-1:0]      op_ff, op_in;
   logic [boae_pkg::ST_W-1:0]       status_ff, status_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [boae_pkg::VAL_W-1:0]      rsp_value_ff, rsp_value_in;
   logic [boae_pkg::POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic [boae_pkg::CNT_O_W-1:0]    rsp_removed_ff, rsp_removed_in;
   logic [boae_pkg::CNT_O_W-1:0]    rsp_fill_ff, rsp_fill_in;
   logic                            rsp_empty_ff, rsp_empty_in;
   logic [boae_pkg::ST_W-1:0]       rsp_status_ff, rsp_status_in;

   logic                            accept;
   logic                            load;
   logic                            is_full;
   logic                            arr_empty;
   logic [CMP_W-1:0]                idx_e;
   logic [CMP_W-1:0]                cnt_e;
   logic [boae_pkg::ST_W-1:0]       chk_status;
   logic                            valid_op;
   logic                            status_ok;

   boae_pkg::walk_cmd_type          w_cmd;
   boae_pkg::walk_sts_type          w_sts;
   logic [WORD_BITS-1:0]            w_value;
   logic [AW-1:0]                   w_pos;
   logic [CW-1:0]                   w_removed;

   assign req_chan.ready = (state_ff == T_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // Admission checks against the current fill.
   always_comb begin
      is_full    = (count_ff == CW'(DEPTH));
      arr_empty  = (count_ff == '0);
      idx_e      = CMP_W'(req_chan.index);
      cnt_e      = CMP_W'(count_ff);
      valid_op   = req_chan.opcode inside {[boae_pkg::OP_PUSH:boae_pkg::OP_REMOVE]};
      chk_status = boae_pkg::ST_OK;
      case (req_chan.opcode)
         boae_pkg::OP_PUSH: begin
            if (is_full) chk_status = boae_pkg::ST_FULL;
         end
         boae_pkg::OP_INSERT: begin
            if (is_full) begin
               chk_status = boae_pkg::ST_FULL;
            end else if (idx_e > cnt_e) begin
               chk_status = boae_pkg::ST_RANGE;
            end
         end
         boae_pkg::OP_POP: begin
            if (arr_empty) chk_status = boae_pkg::ST_EMPTY;
         end
         boae_pkg::OP_DELETE, boae_pkg::OP_READ: begin
            if (arr_empty) begin
               chk_status = boae_pkg::ST_EMPTY;
            end else if (idx_e >= cnt_e) begin
               chk_status = boae_pkg::ST_RANGE;
            end
         end
         default: begin
            chk_status = boae_pkg::ST_OK;
         end
      endcase
   end

   assign w_cmd.start = accept && valid_op && (chk_status == boae_pkg::ST_OK);
   assign w_cmd.op    = req_chan.opcode;

   boae_walker #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .cmd         (w_cmd),
      .cmd_idx     (CW'(req_chan.index)),
      .cmd_cnt     (count_ff),
      .cmd_item    (WORD_BITS'($unsigned(req_chan.item))),
      .sts         (w_sts),
      .res_value   (w_value),
      .res_pos     (w_pos),
      .res_removed (w_removed)
   );

   assign load      = (state_ff == T_HOLD) && (!rsp_valid_ff || rsp_chan.ready);
   assign status_ok = (status_ff == boae_pkg::ST_OK);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      op_in          = op_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in   = rsp_value_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_fill_in    = rsp_fill_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_status_in  = rsp_status_ff;

      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               op_in     = req_chan.opcode;
               status_in = chk_status;
               state_in  = w_cmd.start ? T_BUSY : T_HOLD;
            end
         end
         T_BUSY: begin
            if (w_sts.done) begin
               case (op_ff)
                  boae_pkg::OP_PUSH, boae_pkg::OP_INSERT: count_in = count_ff + CW'(1);
                  boae_pkg::OP_POP, boae_pkg::OP_DELETE:  count_in = count_ff - CW'(1);
                  boae_pkg::OP_REMOVE:                    count_in = count_ff - w_removed;
                  default:                                count_in = count_ff;
               endcase
               state_in = T_HOLD;
            end
         end
         T_HOLD: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               if (status_ok && ((op_ff == boae_pkg::OP_POP) ||
                                 (op_ff == boae_pkg::OP_DELETE) ||
                                 (op_ff == boae_pkg::OP_READ))) begin
                  rsp_value_in = boae_pkg::VAL_W'(w_value);
               end
               rsp_pos_in = '0;
               if (op_ff == boae_pkg::OP_FIND) begin
                  rsp_pos_in = w_sts.found ? boae_pkg::POS_W'(w_pos) : '1;
               end
               rsp_removed_in = (op_ff == boae_pkg::OP_REMOVE) ?
                                boae_pkg::CNT_O_W'(w_removed) : '0;
               rsp_fill_in    = boae_pkg::CNT_O_W'(count_ff);
               rsp_empty_in   = (count_ff == '0);
               rsp_status_in  = status_ff;
               state_in       = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      status_ff      <= status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_fill_ff    <= rsp_fill_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.value         = rsp_value_ff;
   assign rsp_chan.position      = rsp_pos_ff;
   assign rsp_chan.removed_count = rsp_removed_ff;
   assign rsp_chan.fill          = rsp_fill_ff;
   assign rsp_chan.empty_res     = rsp_empty_ff;
   assign rsp_chan.status        = rsp_status_ff;

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above capacity");

   a_count_only_on_done : assert property (@(posedge clock) disable iff (reset)
      !w_sts.done |=> $stable(count_ff))
      else $error("fill count changed without a finished walk");

   a_done_while_busy : assert property (@(posedge clock) disable iff (reset)
      w_sts.done |-> (state_ff == T_BUSY))
      else $error("walk finished while no transaction was in progress");

endmodule
`default_nettype wire
